// ===== rtl/segment_intersection_unit_macros.svh =====
// Assertion shorthands for the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/siu_pkg.sv =====
`timescale 1ns / 1ps

package siu_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;

   // offsets saturate at +-2^OFF_SAT_LOG
   localparam int OFF_SAT_LOG = 40;

   localparam int TOL_W     = 8;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOLERANCE = 1'b0
   } csr_reg_type;

   // about 0.01 in units of 2^-frac, rounded, capped to the register range
   function automatic logic [TOL_W-1:0] tol_reset(input int frac);
      longint e;
      e = ((longint'(1) << frac) + 50) / 100;
      if (e > 255) begin
         e = 255;
      end
      return TOL_W'(e);
   endfunction

endpackage

// ===== rtl/segment_intersection_unit.sv =====
`timescale 1ns / 1ps
// Segment intersection unit: takes two 2-D segments in signed fixed point and
// returns where their lines cross, with hit = 1 only when that point lies in
// both segments' bounding boxes (an axis narrower than the tolerance register
// is widened by it on both sides). parallel = 1 flags a zero denominator.
// cross_x/cross_y are zero without a hit. One word is taken every clock; the
// word passes six front stages (coords, differences, products, num/den,
// magnitudes, partial products), the product stage, OFF_SAT_LOG + 2 = 42
// restoring divider stages (a saturation check, then one quotient bit each),
// an offset stage and the output register. A stall on rsp freezes the whole
// pipeline, so req_stall follows rsp_stall while a result is held.
// The tolerance register sits at byte address 0; write it only while idle.
`include "segment_intersection_unit_macros.svh"

module segment_intersection_unit
   import siu_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg1_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg2_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_parallel,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_AW-1:0]             csr_paddr,
   input  logic [CSR_DW-1:0]             csr_pwdata,
   output logic [CSR_DW-1:0]             csr_prdata,
   output logic                          csr_pready
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;          // coordinate differences
   localparam int PRW = 2 * W + 2;      // difference products
   localparam int NW  = 2 * W + 3;      // num / den
   localparam int MW  = 2 * W + 2;      // |num| / |den|
   localparam int HW  = MW / 2;         // split of |num| for the partial products
   localparam int BW  = W + 1;          // |v2|
   localparam int PPW = HW + BW;
   localparam int PW  = MW + BW;        // |num| * |v2|
   localparam int QB  = OFF_SAT_LOG + 1;
   localparam int RW  = (PW > MW + QB) ? PW : MW + QB;
   localparam int BDW = W + 2;          // widened box bounds
   localparam int OW  = QB + 1;         // signed offset
   localparam int XW  = ((OW > BDW) ? OW : BDW) + 1;
   localparam int NS  = QB + 2;         // product stage plus divider stages

   localparam logic [QB-1:0] QSAT = {1'b1, {(QB - 1){1'b0}}};
   localparam logic signed [XW-1:0] CMAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [XW-1:0] CMIN = {{(XW - W + 1){1'b1}}, {(W - 1){1'b0}}};

   // ---------------------------------------------------------------- CSR
   logic [TOL_W-1:0]     tol_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tol_reset(FRAC_BITS);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TOLERANCE: tol_ff <= csr_pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TOLERANCE: csr_prdata = CSR_DW'(tol_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------ flow control
   // Every stage moves together; nothing moves while a result is held.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------- stage 0: input register
   // coord order: ax ay bx by cx cy dx dy
   logic                s0_vld_ff;
   logic signed [W-1:0] s0_co_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_co_ff[0] <= req_seg1_start_x;
         s0_co_ff[1] <= req_seg1_start_y;
         s0_co_ff[2] <= req_seg1_end_x;
         s0_co_ff[3] <= req_seg1_end_y;
         s0_co_ff[4] <= req_seg2_start_x;
         s0_co_ff[5] <= req_seg2_start_y;
         s0_co_ff[6] <= req_seg2_end_x;
         s0_co_ff[7] <= req_seg2_end_y;
      end
   end

   // ------------------------- stage 1: differences, box min/max per axis
   // diff order: v1x v1y v2x v2y ddx ddy; box axes: s1.x s1.y s2.x s2.y
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_v_ff [6];
   logic signed [DW-1:0] s1_v_in [6];
   logic signed [W-1:0]  s1_lo_ff [4];
   logic signed [W-1:0]  s1_hi_ff [4];
   logic signed [W-1:0]  s1_lo_in [4];
   logic signed [W-1:0]  s1_hi_in [4];
   logic signed [W-1:0]  s1_c_ff [2];

   always_comb begin
      s1_v_in[0] = DW'(s0_co_ff[2]) - DW'(s0_co_ff[0]);
      s1_v_in[1] = DW'(s0_co_ff[3]) - DW'(s0_co_ff[1]);
      s1_v_in[2] = DW'(s0_co_ff[6]) - DW'(s0_co_ff[4]);
      s1_v_in[3] = DW'(s0_co_ff[7]) - DW'(s0_co_ff[5]);
      s1_v_in[4] = DW'(s0_co_ff[4]) - DW'(s0_co_ff[0]);
      s1_v_in[5] = DW'(s0_co_ff[5]) - DW'(s0_co_ff[1]);
      for (int j = 0; j < 4; j++) begin
         // axis j pairs coord (j/2)*4 + j%2 with the one two places later
         if (s0_co_ff[(j / 2) * 4 + (j % 2)] < s0_co_ff[(j / 2) * 4 + (j % 2) + 2]) begin
            s1_lo_in[j] = s0_co_ff[(j / 2) * 4 + (j % 2)];
            s1_hi_in[j] = s0_co_ff[(j / 2) * 4 + (j % 2) + 2];
         end else begin
            s1_lo_in[j] = s0_co_ff[(j / 2) * 4 + (j % 2) + 2];
            s1_hi_in[j] = s0_co_ff[(j / 2) * 4 + (j % 2)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_v_ff  <= s1_v_in;
         s1_lo_ff <= s1_lo_in;
         s1_hi_ff <= s1_hi_in;
         s1_c_ff[0] <= s0_co_ff[4];
         s1_c_ff[1] <= s0_co_ff[5];
      end
   end

   // ------------------------------- stage 2: products, widened box bounds
   // products: v1x*ddy, v1y*ddx, v1y*v2x, v1x*v2y
   logic                  s2_vld_ff;
   logic signed [PRW-1:0] s2_pr_ff [4];
   logic signed [DW-1:0]  s2_v2_ff [2];
   logic signed [BDW-1:0] s2_blo_ff [4];
   logic signed [BDW-1:0] s2_bhi_ff [4];
   logic signed [BDW-1:0] s2_blo_in [4];
   logic signed [BDW-1:0] s2_bhi_in [4];
   logic signed [W-1:0]   s2_c_ff [2];
   logic signed [DW-1:0]  s2_ext [4];
   logic signed [BDW-1:0] s2_slack [4];
   logic signed [TOL_W:0] tol_s;

   assign tol_s = $signed({1'b0, tol_ff});

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s2_ext[j]   = DW'(s1_hi_ff[j]) - DW'(s1_lo_ff[j]);
         s2_slack[j] = (s2_ext[j] < DW'(tol_s)) ? BDW'(tol_s) : '0;
         s2_blo_in[j] = BDW'(s1_lo_ff[j]) - s2_slack[j];
         s2_bhi_in[j] = BDW'(s1_hi_ff[j]) + s2_slack[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pr_ff[0] <= PRW'(s1_v_ff[0]) * PRW'(s1_v_ff[5]);
         s2_pr_ff[1] <= PRW'(s1_v_ff[1]) * PRW'(s1_v_ff[4]);
         s2_pr_ff[2] <= PRW'(s1_v_ff[1]) * PRW'(s1_v_ff[2]);
         s2_pr_ff[3] <= PRW'(s1_v_ff[0]) * PRW'(s1_v_ff[3]);
         s2_v2_ff[0] <= s1_v_ff[2];
         s2_v2_ff[1] <= s1_v_ff[3];
         s2_blo_ff   <= s2_blo_in;
         s2_bhi_ff   <= s2_bhi_in;
         s2_c_ff     <= s1_c_ff;
      end
   end

   // ------------------------------------------------ stage 3: num, den
   logic                  s3_vld_ff;
   logic signed [NW-1:0]  s3_num_ff;
   logic signed [NW-1:0]  s3_den_ff;
   logic signed [DW-1:0]  s3_v2_ff [2];
   logic signed [BDW-1:0] s3_blo_ff [4];
   logic signed [BDW-1:0] s3_bhi_ff [4];
   logic signed [W-1:0]   s3_c_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_num_ff <= NW'(s2_pr_ff[0]) - NW'(s2_pr_ff[1]);
         s3_den_ff <= NW'(s2_pr_ff[2]) - NW'(s2_pr_ff[3]);
         s3_v2_ff  <= s2_v2_ff;
         s3_blo_ff <= s2_blo_ff;
         s3_bhi_ff <= s2_bhi_ff;
         s3_c_ff   <= s2_c_ff;
      end
   end

   // ---------------------------------------- stage 4: magnitudes, signs
   logic                  s4_vld_ff;
   logic [MW-1:0]         s4_nm_ff;
   logic [MW-1:0]         s4_dm_ff;
   logic [BW-1:0]         s4_bm_ff [2];
   logic                  s4_neg_ff [2];
   logic                  s4_par_ff;
   logic signed [BDW-1:0] s4_blo_ff [4];
   logic signed [BDW-1:0] s4_bhi_ff [4];
   logic signed [W-1:0]   s4_c_ff [2];
   logic signed [NW-1:0]  s4_nabs;
   logic signed [NW-1:0]  s4_dabs;
   logic signed [DW-1:0]  s4_vabs [2];

   always_comb begin
      s4_nabs = s3_num_ff[NW-1] ? -s3_num_ff : s3_num_ff;
      s4_dabs = s3_den_ff[NW-1] ? -s3_den_ff : s3_den_ff;
      for (int a = 0; a < 2; a++) begin
         s4_vabs[a] = s3_v2_ff[a][DW-1] ? -s3_v2_ff[a] : s3_v2_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_nm_ff <= MW'(s4_nabs);
         s4_dm_ff <= MW'(s4_dabs);
         for (int a = 0; a < 2; a++) begin
            s4_bm_ff[a]  <= BW'(s4_vabs[a]);
            s4_neg_ff[a] <= s3_num_ff[NW-1] ^ s3_v2_ff[a][DW-1] ^ s3_den_ff[NW-1];
         end
         s4_par_ff <= (s3_den_ff == '0);
         s4_blo_ff <= s3_blo_ff;
         s4_bhi_ff <= s3_bhi_ff;
         s4_c_ff   <= s3_c_ff;
      end
   end

   // --------------------------- stage 5: partial products |num| * |v2|
   logic                  s5_vld_ff;
   logic [PPW-1:0]        s5_pl_ff [2];
   logic [PPW-1:0]        s5_ph_ff [2];
   logic [MW-1:0]         s5_dm_ff;
   logic                  s5_neg_ff [2];
   logic                  s5_par_ff;
   logic signed [BDW-1:0] s5_blo_ff [4];
   logic signed [BDW-1:0] s5_bhi_ff [4];
   logic signed [W-1:0]   s5_c_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            s5_pl_ff[a] <= PPW'(s4_nm_ff[HW-1:0]) * PPW'(s4_bm_ff[a]);
            s5_ph_ff[a] <= PPW'(s4_nm_ff[MW-1:HW]) * PPW'(s4_bm_ff[a]);
         end
         s5_dm_ff  <= s4_dm_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_par_ff <= s4_par_ff;
         s5_blo_ff <= s4_blo_ff;
         s5_bhi_ff <= s4_bhi_ff;
         s5_c_ff   <= s4_c_ff;
      end
   end

   // ------------------------------- product stage and divider pipeline
   // Slot 0 holds the full product; slot 1 checks for quotient >= 2^QB
   // (saturation); slots 2..QB+1 resolve quotient bits QB-1 down to 0.
   logic                  dv_vld_ff [NS];
   logic [RW-1:0]         dv_r_ff   [NS][2];
   logic [QB-1:0]         dv_q_ff   [NS][2];
   logic                  dv_sat_ff [NS][2];
   logic [MW-1:0]         dv_dm_ff  [NS];
   logic                  dv_neg_ff [NS][2];
   logic                  dv_par_ff [NS];
   logic signed [BDW-1:0] dv_blo_ff [NS][4];
   logic signed [BDW-1:0] dv_bhi_ff [NS][4];
   logic signed [W-1:0]   dv_c_ff   [NS][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            dv_r_ff[0][a]   <= RW'({s5_ph_ff[a], {HW{1'b0}}}) + RW'(s5_pl_ff[a]);
            dv_q_ff[0][a]   <= '0;
            dv_sat_ff[0][a] <= 1'b0;
         end
         dv_dm_ff[0]  <= s5_dm_ff;
         dv_neg_ff[0] <= s5_neg_ff;
         dv_par_ff[0] <= s5_par_ff;
         dv_blo_ff[0] <= s5_blo_ff;
         dv_bhi_ff[0] <= s5_bhi_ff;
         dv_c_ff[0]   <= s5_c_ff;
      end
   end

   for (genvar i = 1; i < NS; i++) begin : g_div
      localparam int K = QB + 1 - i;
      logic [RW-1:0] dsub;
      logic          ge    [2];
      logic [RW-1:0] r_in  [2];
      logic [QB-1:0] q_in  [2];
      logic          sat_in[2];

      assign dsub = RW'(dv_dm_ff[i-1]) << K;

      if (i == 1) begin : g_sat
         always_comb begin
            for (int a = 0; a < 2; a++) begin
               ge[a]     = dv_r_ff[i-1][a] >= dsub;
               r_in[a]   = dv_r_ff[i-1][a];
               q_in[a]   = dv_q_ff[i-1][a];
               sat_in[a] = ge[a];
            end
         end
      end else begin : g_bit
         always_comb begin
            for (int a = 0; a < 2; a++) begin
               ge[a]     = dv_r_ff[i-1][a] >= dsub;
               r_in[a]   = dv_r_ff[i-1][a];
               q_in[a]   = dv_q_ff[i-1][a];
               sat_in[a] = dv_sat_ff[i-1][a];
               if (ge[a]) begin
                  r_in[a]    = dv_r_ff[i-1][a] - dsub;
                  q_in[a][K] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_r_ff[i]   <= r_in;
            dv_q_ff[i]   <= q_in;
            dv_sat_ff[i] <= sat_in;
            dv_dm_ff[i]  <= dv_dm_ff[i-1];
            dv_neg_ff[i] <= dv_neg_ff[i-1];
            dv_par_ff[i] <= dv_par_ff[i-1];
            dv_blo_ff[i] <= dv_blo_ff[i-1];
            dv_bhi_ff[i] <= dv_bhi_ff[i-1];
            dv_c_ff[i]   <= dv_c_ff[i-1];
         end
      end
   end

   // ------------------------------ offset stage: clamp, sign, add start
   logic                  f_vld_ff;
   logic signed [XW-1:0]  f_p_ff [2];
   logic signed [XW-1:0]  f_p_in [2];
   logic                  f_par_ff;
   logic signed [BDW-1:0] f_blo_ff [4];
   logic signed [BDW-1:0] f_bhi_ff [4];
   logic [QB-1:0]         f_qm [2];
   logic signed [OW-1:0]  f_mag [2];
   logic signed [OW-1:0]  f_off [2];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         f_qm[a]  = (dv_sat_ff[NS-1][a] || dv_q_ff[NS-1][a] > QSAT) ? QSAT
                                                                 : dv_q_ff[NS-1][a];
         f_mag[a] = $signed({1'b0, f_qm[a]});
         f_off[a] = dv_neg_ff[NS-1][a] ? -f_mag[a] : f_mag[a];
         f_p_in[a] = XW'(dv_c_ff[NS-1][a]) + XW'(f_off[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= dv_vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_p_ff   <= f_p_in;
         f_par_ff <= dv_par_ff[NS-1];
         f_blo_ff <= dv_blo_ff[NS-1];
         f_bhi_ff <= dv_bhi_ff[NS-1];
      end
   end

   // ---------------------------------- output stage: box test and clamp
   logic                rsp_hit_ff;
   logic                rsp_par_ff;
   logic signed [W-1:0] rsp_x_ff;
   logic signed [W-1:0] rsp_y_ff;
   logic [3:0]          o_inb;
   logic                o_hit;
   logic signed [W-1:0] o_emit [2];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         o_inb[j] = (f_p_ff[j % 2] >= XW'(f_blo_ff[j])) &&
                    (f_p_ff[j % 2] <= XW'(f_bhi_ff[j]));
      end
      o_hit = !f_par_ff && (&o_inb);
      for (int a = 0; a < 2; a++) begin
         if (f_p_ff[a] > CMAX) begin
            o_emit[a] = W'(CMAX);
         end else if (f_p_ff[a] < CMIN) begin
            o_emit[a] = W'(CMIN);
         end else begin
            o_emit[a] = W'(f_p_ff[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= o_hit;
         rsp_par_ff <= f_par_ff;
         rsp_x_ff   <= o_hit ? o_emit[0] : '0;
         rsp_y_ff   <= o_hit ? o_emit[1] : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_parallel = rsp_par_ff;
   assign rsp_cross_x  = rsp_x_ff;
   assign rsp_cross_y  = rsp_y_ff;

   // --------------------------------------------------------- checks
   `SIU_ASSERT_NOW(a_par_no_hit, rsp_valid_ff && rsp_par_ff, !rsp_hit_ff, "hit on parallel")
   `SIU_ASSERT_NOW(a_miss_zero, rsp_valid_ff && !rsp_hit_ff,
      rsp_x_ff == '0 && rsp_y_ff == '0, "nonzero point without hit")
   `SIU_ASSERT_NOW(a_stall_src, req_stall, rsp_valid_ff && rsp_stall,
      "input stalled without a held result")
   `SIU_ASSERT_NEXT(a_pipe_move, adv && !reset, rsp_valid_ff == $past(f_vld_ff),
      "output valid lost or invented")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import siu_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int LATENCY   = 51;
   localparam int CYCLE_CAP = 400000;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_t;
   typedef logic signed [127:0]  wide_t;

   typedef struct {
      coord_t ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_t;

   typedef struct {
      logic   hit;
      logic   parallel;
      coord_t x;
      coord_t y;
   } crossing_t;

   // Expected crossings, in order of acceptance, plus a private copy of the
   // tolerance register.
   class crossing_board;
      logic [TOL_W-1:0] tolerance;
      crossing_t        pending[$];
      int               mismatches;
      int               strays;

      function new();
         tolerance  = tol_reset(FRAC_BITS_DEF);
         mismatches = 0;
         strays     = 0;
      endfunction

      function bit in_box(wide_t p, wide_t a, wide_t b);
         wide_t lo, hi, slack;
         lo    = (a < b) ? a : b;
         hi    = (a < b) ? b : a;
         slack = ((hi - lo) < wide_t'(tolerance)) ? wide_t'(tolerance) : wide_t'(0);
         return (p >= lo - slack) && (p <= hi + slack);
      endfunction

      function coord_t clamp(wide_t v);
         if (v > wide_t'(CMAX)) v = wide_t'(CMAX);
         if (v < wide_t'(CMIN)) v = wide_t'(CMIN);
         return v[CW-1:0];
      endfunction

      function wide_t clip_offset(wide_t v);
         wide_t lim;
         lim = wide_t'(1) <<< OFF_SAT_LOG;
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function crossing_t predict_crossing(seg_pair_t s);
         wide_t ax, ay, bx, by, cx, cy, dx, dy;
         wide_t v1x, v1y, v2x, v2y, num, den, px, py;
         crossing_t r;
         ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
         cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
         v1x = bx - ax; v1y = by - ay; v2x = dx - cx; v2y = dy - cy;
         num = v1x * (cy - ay) - v1y * (cx - ax);
         den = v1y * v2x - v1x * v2y;
         r = '{hit: 1'b0, parallel: 1'b0, x: '0, y: '0};
         if (den == 0) begin
            r.parallel = 1'b1;
            return r;
         end
         // signed division truncates toward zero
         px = cx + clip_offset((v2x * num) / den);
         py = cy + clip_offset((v2y * num) / den);
         if (in_box(px, ax, bx) && in_box(py, ay, by) &&
             in_box(px, cx, dx) && in_box(py, cy, dy)) begin
            r.hit = 1'b1;
            r.x   = clamp(px);
            r.y   = clamp(py);
         end
         return r;
      endfunction

      function void note(seg_pair_t s);
         pending.push_back(predict_crossing(s));
      endfunction

      function void check(crossing_t got);
         crossing_t want;
         if (pending.size() == 0) begin
            strays++;
            if (strays + mismatches <= 10)
               $display("unexpected result word: hit=%0b par=%0b x=%0d y=%0d",
                        got.hit, got.parallel, got.x, got.y);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit || got.parallel !== want.parallel ||
             got.x !== want.x || got.y !== want.y) begin
            mismatches++;
            if (strays + mismatches <= 10)
               $display({"mismatch: want hit=%0b par=%0b x=%0d y=%0d, ",
                         "got hit=%0b par=%0b x=%0d y=%0d"},
                        want.hit, want.parallel, want.x, want.y,
                        got.hit, got.parallel, got.x, got.y);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic   req_valid = 1'b0;
   logic   req_stall;
   coord_t req_seg1_start_x = '0, req_seg1_start_y = '0;
   coord_t req_seg1_end_x = '0, req_seg1_end_y = '0;
   coord_t req_seg2_start_x = '0, req_seg2_start_y = '0;
   coord_t req_seg2_end_x = '0, req_seg2_end_y = '0;

   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   logic   rsp_hit, rsp_parallel;
   coord_t rsp_cross_x, rsp_cross_y;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   crossing_board board = new();
   int send_idle = 0;   // percent of cycles the sender holds off
   int recv_idle = 0;   // percent of cycles the receiver stalls
   int cycles = 0;

   always #2 clock = ~clock;

   segment_intersection_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_seg1_start_x (req_seg1_start_x),
      .req_seg1_start_y (req_seg1_start_y),
      .req_seg1_end_x   (req_seg1_end_x),
      .req_seg1_end_y   (req_seg1_end_y),
      .req_seg2_start_x (req_seg2_start_x),
      .req_seg2_start_y (req_seg2_start_y),
      .req_seg2_end_x   (req_seg2_end_x),
      .req_seg2_end_y   (req_seg2_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_parallel     (rsp_parallel),
      .rsp_cross_x      (rsp_cross_x),
      .rsp_cross_y      (rsp_cross_y),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Input monitor: signals are read before this edge's updates land, so a
   // word counts exactly when valid was high and stall low going into it.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note('{req_seg1_start_x, req_seg1_start_y, req_seg1_end_x, req_seg1_end_y,
                      req_seg2_start_x, req_seg2_start_y, req_seg2_end_x, req_seg2_end_y});
   end

   // Output side: check accepted words and throttle with random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check('{rsp_hit, rsp_parallel, rsp_cross_x, rsp_cross_y});
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // Called at a rising edge; returns at the edge that took the word, so the
   // next call drives in that same step without dropping valid in between.
   task automatic send_pair(seg_pair_t s);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_seg1_start_x <= s.ax;
      req_seg1_start_y <= s.ay;
      req_seg1_end_x   <= s.bx;
      req_seg1_end_y   <= s.by;
      req_seg2_start_x <= s.cx;
      req_seg2_start_y <= s.cy;
      req_seg2_end_x   <= s.dx;
      req_seg2_end_y   <= s.dy;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and let every outstanding word drain, then let the pipe empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // Two-phase register write; the register takes the value at the access edge.
   task automatic write_tolerance(logic [TOL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_TOLERANCE, 2'b00};
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.tolerance = value;
   endtask

   function automatic seg_pair_t pair(int ax, int ay, int bx, int by,
                                      int cx, int cy, int dx, int dy);
      return '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
               coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy)};
   endfunction

   // Signed value of random magnitude: arithmetic shift keeps the sign bit.
   function automatic coord_t rand_coord(int bits);
      coord_t v;
      v = coord_t'($urandom);
      return v >>> (CW - bits);
   endfunction

   // Mostly pairs built around a shared crossing point so the box checks get
   // real work; the rest is parallel, axis-aligned and raw noise.
   function automatic seg_pair_t random_pair();
      seg_pair_t s;
      coord_t px, py, jit;
      int bits, kind;
      bits = $urandom_range(3, CW);
      kind = $urandom_range(9);
      px = rand_coord(CW);
      py = rand_coord(CW);
      s.ax = px + rand_coord(bits);
      s.ay = py + rand_coord(bits);
      s.cx = px + rand_coord(bits);
      s.cy = py + rand_coord(bits);
      jit = rand_coord(4);
      case (kind)
         0, 1, 2, 3, 4: begin
            // midpoint crossing, small skew on the far ends
            s.bx = coord_t'(2 * px - s.ax + ($urandom_range(3) == 0 ? jit : 0));
            s.by = coord_t'(2 * py - s.ay);
            s.dx = coord_t'(2 * px - s.cx);
            s.dy = coord_t'(2 * py - s.cy + ($urandom_range(3) == 0 ? jit : 0));
         end
         5: begin
            // same direction, offset line
            s.bx = px;
            s.by = py;
            s.dx = s.cx + (px - s.ax);
            s.dy = s.cy + (py - s.ay);
         end
         6: begin
            // thin boxes: one axis flat or within a few units
            s.by = s.ay + coord_t'($urandom_range(4));
            s.bx = coord_t'(2 * px - s.ax);
            s.dx = s.cx + coord_t'($urandom_range(4));
            s.dy = coord_t'(2 * py - s.cy);
         end
         default: begin
            s = '{rand_coord(CW), rand_coord(CW), rand_coord(CW), rand_coord(CW),
                  rand_coord(CW), rand_coord(CW), rand_coord(CW), rand_coord(CW)};
         end
      endcase
      return s;
   endfunction

   initial begin
      seg_pair_t directed[$];
      int        a;
      logic [TOL_W-1:0] tol_plan[6];

      a = 1 << 22;
      directed = '{
         pair(0, 0, 0, 0, 0, 0, 0, 0),                              // all degenerate
         pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
         pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN),
         pair(-256, -256, 256, 256, -256, 256, 256, -256),          // plain X
         pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN),      // full-range X
         pair(0, 0, 100, 100, 0, 10, 100, 110),                     // parallel
         pair(0, 0, 100, 0, 50, 0, 200, 0),                         // collinear
         pair(0, 0, 100, 0, 100, -50, 100, 50),                     // touch at end
         pair(0, 0, 100, 0, 200, -50, 200, 50),                     // clear miss
         pair(-100, 0, 100, 0, 2, -50, 3, 50),                      // thin box widened
         pair(0, -100, 0, 100, -50, 7, 50, -3),                     // odd slope trunc
         pair(0, 0, 3, 1, 1, -5, 0, 5),                             // negative trunc
         pair(CMIN, CMIN, CMIN + a, CMIN + a - 1,                   // huge offset
              CMIN, 0, CMIN + a - 1, a - 2),
         pair(3, CMAX - 2, 3, CMAX, 0, CMAX - 2, 2, CMAX),          // beyond top
         pair(3, CMIN + 2, 3, CMIN, 0, CMIN + 2, 2, CMIN),          // beyond bottom
         pair(CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN),                  // axes, full span
         pair(5, 5, 5, 5, 0, 0, 10, 10)                             // point segment
      };
      tol_plan = '{tol_reset(FRAC_BITS_DEF), 8'd0, 8'd255, TOL_W'($urandom),
                   8'd1, TOL_W'($urandom)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Six phases: sender-light/receiver-heavy, swapped, then no idling;
      // the tolerance changes only between phases with the pipe empty.
      for (int p = 0; p < 6; p++) begin
         send_idle = (p < 2) ? 27 : (p < 4) ? 86 : 0;
         recv_idle = (p < 2) ? 86 : (p < 4) ? 27 : 0;
         if (p != 0) begin
            drain();
            write_tolerance(tol_plan[p]);
         end
         if (p == 0 || p == 2)
            foreach (directed[i]) send_pair(directed[i]);
         for (int n = 0; n < 255; n++) begin
            if (p == 1 && n == 120)
               drain();   // sender holds until every result is back
            send_pair(random_pair());
         end
      end

      drain();
      if (board.mismatches == 0 && board.strays == 0 && board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
